// ===== src/rrts_pkg.sv =====
package rrts_pkg;

   localparam int NUM_TASKS = 16;
   localparam int TASK_W    = $clog2(NUM_TASKS);
   localparam int POS_W     = $clog2(NUM_TASKS + 1);
   localparam int MODE_W    = 3;
   localparam int SLICE_W   = 8;
   localparam int TICKS_W   = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [SLICE_W-1:0] SLICE_DEFAULT = 8'd10;

   localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_YIELD    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_TIME_SLICE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCHED_ENABLE = 1'd1;

   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_PUSH   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [TASK_W-1:0] id;
      logic [POS_W-1:0]  pos;
   } cmd_type;

   typedef struct packed {
      logic              vld;
      logic [TASK_W-1:0] id;
   } entry_type;

endpackage

// ===== src/rrts_cell.sv =====
module rrts_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rrts_pkg::cmd_type       cmd,
   input  logic [rrts_pkg::POS_W-1:0] pos_idx,
   input  rrts_pkg::entry_type     nbr,
   input  logic                    shift_in,
   output rrts_pkg::entry_type     entry,
   output logic                    shift_out
);

   rrts_pkg::entry_type entry_ff;
   rrts_pkg::entry_type entry_in;
   logic                hit;

   always_comb begin
      hit       = entry_ff.vld && (entry_ff.id == cmd.id) && (cmd.op == rrts_pkg::OP_REMOVE);
      shift_out = shift_in | hit;
      entry_in  = entry_ff;
      if ((cmd.op == rrts_pkg::OP_REMOVE) && shift_out) begin
         entry_in = nbr;
      end else if ((cmd.op == rrts_pkg::OP_PUSH) && (cmd.pos == pos_idx)) begin
         entry_in.vld = 1'b1;
         entry_in.id  = cmd.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.vld <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== src/rrts_chain.sv =====
module rrts_chain (
   input  logic                        clock,
   input  logic                        reset,
   input  rrts_pkg::cmd_type           cmd,
   output logic [rrts_pkg::TASK_W-1:0] head_id
);

   rrts_pkg::entry_type ent [rrts_pkg::NUM_TASKS];
   rrts_pkg::entry_type nbr [rrts_pkg::NUM_TASKS];
   logic [rrts_pkg::NUM_TASKS:0] shift;

   assign shift[0] = 1'b0;

   for (genvar k = 0; k < rrts_pkg::NUM_TASKS; k++) begin : g_cell
      if (k == rrts_pkg::NUM_TASKS - 1) begin : g_last
         assign nbr[k] = '0;
      end else begin : g_mid
         assign nbr[k] = ent[k+1];
      end

      rrts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .pos_idx   (rrts_pkg::POS_W'(k)),
         .nbr       (nbr[k]),
         .shift_in  (shift[k]),
         .entry     (ent[k]),
         .shift_out (shift[k+1])
      );
   end

   assign head_id = ent[0].id;

endmodule

// ===== src/round_robin_time_slice_scheduler_unit.sv =====
// Round-robin time-slice scheduler for 16 tasks. The ready queue is a row of
// cells in arrival order: a push writes the cell at the tail position, and a
// removal makes every cell from the match onward take its upper neighbor's
// entry. An item passes through the accept, evaluate and result states
// before its result is loaded, with a take state between evaluate and result
// when tasks are waiting and a tick expires the slice or a yield comes, since
// the requeue of the current task and the pop of the head are two separate
// steps through the chain. The next item is taken as soon as the result is
// loaded, even while the result beat is still stalled; a further result waits
// for the output register to drain. Configuration: index 0 is time_slice,
// index 1 is sched_enable; writes are always taken.
module round_robin_time_slice_scheduler_unit (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rrts_pkg::MODE_W-1:0]    req_mode,
   input  logic [rrts_pkg::TASK_W-1:0]    req_task_id,
   input  logic                           req_runnable,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rrts_pkg::TASK_W-1:0]    rsp_next_task,
   output logic [rrts_pkg::TASK_W-1:0]    rsp_prev_task,
   output logic                           rsp_switched,
   output logic                           rsp_idle_chosen,
   output logic                           rsp_accepted,
   output logic [rrts_pkg::POS_W-1:0]     rsp_ready_count,
   output logic [rrts_pkg::SLICE_W-1:0]   rsp_slice_remaining,
   output logic [rrts_pkg::TICKS_W-1:0]   rsp_current_run_ticks,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rrts_pkg::CSR_DAT_W-1:0] csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_TAKE = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [rrts_pkg::SLICE_W-1:0] time_slice_ff;
   logic                         sched_enable_ff;

   logic [rrts_pkg::MODE_W-1:0] item_mode_ff, item_mode_in;
   logic [rrts_pkg::TASK_W-1:0] item_id_ff, item_id_in;
   logic                        item_run_ff, item_run_in;

   logic [rrts_pkg::TASK_W-1:0]    cur_ff, cur_in;
   logic                           cur_valid_ff, cur_valid_in;
   logic [rrts_pkg::SLICE_W-1:0]   slice_ff, slice_in;
   logic [rrts_pkg::POS_W-1:0]     count_ff, count_in;
   logic [rrts_pkg::NUM_TASKS-1:0] queued_mark_ff, queued_mark_in;
   logic [rrts_pkg::TICKS_W-1:0]   run_ticks_ff [rrts_pkg::NUM_TASKS];
   logic                           tick_inc;

   logic [rrts_pkg::TASK_W-1:0] prev_ff, prev_in;
   logic                        sw_ff, sw_in;
   logic                        idle_ff, idle_in;
   logic                        acc_ff, acc_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::TASK_W-1:0]    rsp_next_ff, rsp_next_in;
   logic [rrts_pkg::TASK_W-1:0]    rsp_prev_ff, rsp_prev_in;
   logic                           rsp_sw_ff, rsp_sw_in;
   logic                           rsp_idle_ff, rsp_idle_in;
   logic                           rsp_acc_ff, rsp_acc_in;
   logic [rrts_pkg::POS_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [rrts_pkg::SLICE_W-1:0]   rsp_slice_ff, rsp_slice_in;
   logic [rrts_pkg::TICKS_W-1:0]   rsp_ticks_ff, rsp_ticks_in;

   rrts_pkg::cmd_type           cmd;
   logic [rrts_pkg::TASK_W-1:0] head_id;
   logic [rrts_pkg::SLICE_W-1:0] slice_dec;

   rrts_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .head_id (head_id)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign slice_dec = (slice_ff != '0) ? slice_ff - 1'b1 : '0;

   always_comb begin
      state_in       = state_ff;
      item_mode_in   = item_mode_ff;
      item_id_in     = item_id_ff;
      item_run_in    = item_run_ff;
      cur_in         = cur_ff;
      cur_valid_in   = cur_valid_ff;
      slice_in       = slice_ff;
      count_in       = count_ff;
      queued_mark_in = queued_mark_ff;
      tick_inc       = 1'b0;
      prev_in        = prev_ff;
      sw_in          = sw_ff;
      idle_in        = idle_ff;
      acc_in         = acc_ff;
      cmd.op         = rrts_pkg::OP_NONE;
      cmd.id         = item_id_ff;
      cmd.pos        = count_ff;

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_next_in  = rsp_next_ff;
      rsp_prev_in  = rsp_prev_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_count_in = rsp_count_ff;
      rsp_slice_in = rsp_slice_ff;
      rsp_ticks_in = rsp_ticks_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_mode_in = req_mode;
               item_id_in   = req_task_id;
               item_run_in  = req_runnable;
               prev_in      = cur_valid_ff ? cur_ff : '0;
               sw_in        = 1'b0;
               idle_in      = 1'b0;
               acc_in       = 1'b0;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_RESP;
            case (item_mode_ff)
               rrts_pkg::MODE_ADD: begin
                  if (item_run_ff && !queued_mark_ff[item_id_ff]) begin
                     acc_in                     = 1'b1;
                     cmd.op                     = rrts_pkg::OP_PUSH;
                     queued_mark_in[item_id_ff] = 1'b1;
                     count_in                   = count_ff + 1'b1;
                  end
               end
               rrts_pkg::MODE_REMOVE: begin
                  if (queued_mark_ff[item_id_ff]) begin
                     acc_in                     = 1'b1;
                     cmd.op                     = rrts_pkg::OP_REMOVE;
                     queued_mark_in[item_id_ff] = 1'b0;
                     count_in                   = count_ff - 1'b1;
                  end
               end
               rrts_pkg::MODE_DISPATCH: begin
                  acc_in       = 1'b1;
                  cur_valid_in = 1'b1;
                  slice_in     = time_slice_ff;
                  if (count_ff == '0) begin
                     cur_in  = '0;
                     idle_in = 1'b1;
                  end else begin
                     cur_in                  = head_id;
                     cmd.op                  = rrts_pkg::OP_REMOVE;
                     cmd.id                  = head_id;
                     queued_mark_in[head_id] = 1'b0;
                     count_in                = count_ff - 1'b1;
                  end
               end
               rrts_pkg::MODE_TICK: begin
                  if (sched_enable_ff && cur_valid_ff) begin
                     acc_in   = 1'b1;
                     tick_inc = 1'b1;
                     slice_in = slice_dec;
                     if (slice_dec == '0) begin
                        if (count_ff != '0) begin
                           state_in = S_TAKE;
                           if (item_run_ff && !queued_mark_ff[cur_ff]) begin
                              cmd.op                 = rrts_pkg::OP_PUSH;
                              cmd.id                 = cur_ff;
                              queued_mark_in[cur_ff] = 1'b1;
                              count_in               = count_ff + 1'b1;
                           end
                        end else begin
                           slice_in = time_slice_ff;
                        end
                     end
                  end
               end
               rrts_pkg::MODE_YIELD: begin
                  if (sched_enable_ff && cur_valid_ff) begin
                     acc_in = 1'b1;
                     if (count_ff != '0) begin
                        state_in = S_TAKE;
                        if (item_run_ff && !queued_mark_ff[cur_ff]) begin
                           cmd.op                 = rrts_pkg::OP_PUSH;
                           cmd.id                 = cur_ff;
                           queued_mark_in[cur_ff] = 1'b1;
                           count_in               = count_ff + 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  acc_in = 1'b0;
               end
            endcase
         end
         S_TAKE: begin
            cmd.op                  = rrts_pkg::OP_REMOVE;
            cmd.id                  = head_id;
            queued_mark_in[head_id] = 1'b0;
            count_in                = count_ff - 1'b1;
            slice_in                = time_slice_ff;
            if (head_id != cur_ff) begin
               cur_in = head_id;
               sw_in  = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_next_in  = cur_valid_ff ? cur_ff : '0;
               rsp_prev_in  = prev_ff;
               rsp_sw_in    = sw_ff;
               rsp_idle_in  = idle_ff;
               rsp_acc_in   = acc_ff;
               rsp_count_in = count_ff;
               rsp_slice_in = slice_ff;
               rsp_ticks_in = cur_valid_ff ? run_ticks_ff[cur_ff] : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         time_slice_ff   <= rrts_pkg::SLICE_DEFAULT;
         sched_enable_ff <= 1'b0;
         cur_ff          <= '0;
         cur_valid_ff    <= 1'b0;
         slice_ff        <= '0;
         count_ff        <= '0;
         queued_mark_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_ff         <= cur_in;
         cur_valid_ff   <= cur_valid_in;
         slice_ff       <= slice_in;
         count_ff       <= count_in;
         queued_mark_ff <= queued_mark_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rrts_pkg::REG_TIME_SLICE:   time_slice_ff   <= csr_data;
               rrts_pkg::REG_SCHED_ENABLE: sched_enable_ff <= csr_data[0];
               default:                    time_slice_ff   <= time_slice_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rrts_pkg::NUM_TASKS; i++) begin
            run_ticks_ff[i] <= '0;
         end
      end else if (tick_inc) begin
         run_ticks_ff[cur_ff] <= run_ticks_ff[cur_ff] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff <= item_mode_in;
      item_id_ff   <= item_id_in;
      item_run_ff  <= item_run_in;
      prev_ff      <= prev_in;
      sw_ff        <= sw_in;
      idle_ff      <= idle_in;
      acc_ff       <= acc_in;
      rsp_next_ff  <= rsp_next_in;
      rsp_prev_ff  <= rsp_prev_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_idle_ff  <= rsp_idle_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_count_ff <= rsp_count_in;
      rsp_slice_ff <= rsp_slice_in;
      rsp_ticks_ff <= rsp_ticks_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_next_task         = rsp_next_ff;
   assign rsp_prev_task         = rsp_prev_ff;
   assign rsp_switched          = rsp_sw_ff;
   assign rsp_idle_chosen       = rsp_idle_ff;
   assign rsp_accepted          = rsp_acc_ff;
   assign rsp_ready_count       = rsp_count_ff;
   assign rsp_slice_remaining   = rsp_slice_ff;
   assign rsp_current_run_ticks = rsp_ticks_ff;

   a_count_matches_marks: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_mark_ff) == 32'(count_ff))
      else $error("ready count disagrees with queued marks");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAKE) |-> (count_ff != '0))
      else $error("head taken from an empty queue");

   a_idle_is_task0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_idle_ff) |-> (rsp_next_ff == '0 && rsp_acc_ff))
      else $error("idle dispatch did not select task 0");

   a_switch_changes_task: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sw_ff) |-> (rsp_next_ff != rsp_prev_ff && rsp_acc_ff))
      else $error("switch reported without a task change");

   a_dispatch_sets_current: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && item_mode_ff == rrts_pkg::MODE_DISPATCH) |=> cur_valid_ff)
      else $error("dispatch left no current task");

endmodule

// ===== sim/round_robin_time_slice_scheduler_unit_tb.sv =====
module round_robin_time_slice_scheduler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 50;
   localparam logic [rrts_pkg::MODE_W-1:0] MODE_BAD_LO = 3'd5;
   localparam logic [rrts_pkg::MODE_W-1:0] MODE_BAD_HI = 3'd7;

   typedef struct packed {
      logic [rrts_pkg::TASK_W-1:0]  next_task;
      logic [rrts_pkg::TASK_W-1:0]  prev_task;
      logic                         switched;
      logic                         idle_chosen;
      logic                         accepted;
      logic [rrts_pkg::POS_W-1:0]   ready_count;
      logic [rrts_pkg::SLICE_W-1:0] slice_remaining;
      logic [rrts_pkg::TICKS_W-1:0] run_ticks;
   } sched_result_type;

   typedef struct {
      bit                             is_csr;
      logic [rrts_pkg::CSR_IDX_W-1:0] idx;
      logic [rrts_pkg::CSR_DAT_W-1:0] data;
      logic [rrts_pkg::MODE_W-1:0]    mode;
      logic [rrts_pkg::TASK_W-1:0]    tid;
      logic                           run;
      bit                             typed;
      sched_result_type               res;
   } step_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [rrts_pkg::MODE_W-1:0]    req_mode;
   logic [rrts_pkg::TASK_W-1:0]    req_task_id;
   logic                           req_runnable;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [rrts_pkg::TASK_W-1:0]    rsp_next_task;
   logic [rrts_pkg::TASK_W-1:0]    rsp_prev_task;
   logic                           rsp_switched;
   logic                           rsp_idle_chosen;
   logic                           rsp_accepted;
   logic [rrts_pkg::POS_W-1:0]     rsp_ready_count;
   logic [rrts_pkg::SLICE_W-1:0]   rsp_slice_remaining;
   logic [rrts_pkg::TICKS_W-1:0]   rsp_current_run_ticks;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [rrts_pkg::CSR_IDX_W-1:0] csr_index;
   logic [rrts_pkg::CSR_DAT_W-1:0] csr_data;

   bit                             beat_typed;
   sched_result_type               beat_res;

   logic [rrts_pkg::TASK_W-1:0]    ready_line[$];
   bit                             in_line[rrts_pkg::NUM_TASKS];
   logic [rrts_pkg::TASK_W-1:0]    cur_task;
   bit                             cur_live;
   logic [rrts_pkg::SLICE_W-1:0]   slice_count;
   logic [rrts_pkg::TICKS_W-1:0]   run_tally[rrts_pkg::NUM_TASKS];
   logic [rrts_pkg::SLICE_W-1:0]   cfg_slice;
   bit                             cfg_enable;

   sched_result_type               pending_results[$];
   step_row_type                   dir_rows[$];
   int                             fail_count;
   bit                             quiet;
   bit                             pressure_on;
   bit                             pressure_done;

   round_robin_time_slice_scheduler_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_task_id           (req_task_id),
      .req_runnable          (req_runnable),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_next_task         (rsp_next_task),
      .rsp_prev_task         (rsp_prev_task),
      .rsp_switched          (rsp_switched),
      .rsp_idle_chosen       (rsp_idle_chosen),
      .rsp_accepted          (rsp_accepted),
      .rsp_ready_count       (rsp_ready_count),
      .rsp_slice_remaining   (rsp_slice_remaining),
      .rsp_current_run_ticks (rsp_current_run_ticks),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic bit enqueue_task(input logic [rrts_pkg::TASK_W-1:0] t);
      if (in_line[t]) return 1'b0;
      ready_line.push_back(t);
      in_line[t] = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit dequeue_task(input logic [rrts_pkg::TASK_W-1:0] t);
      if (!in_line[t]) return 1'b0;
      for (int i = 0; i < ready_line.size(); i++) begin
         if (ready_line[i] == t) begin
            ready_line.delete(i);
            break;
         end
      end
      in_line[t] = 1'b0;
      return 1'b1;
   endfunction

   function automatic bit promote_head();
      logic [rrts_pkg::TASK_W-1:0] nx;
      nx = ready_line[0];
      void'(dequeue_task(nx));
      slice_count = cfg_slice;
      if (nx != cur_task) begin
         cur_task = nx;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic sched_result_type schedule_event(
         input logic [rrts_pkg::MODE_W-1:0] m,
         input logic [rrts_pkg::TASK_W-1:0] t,
         input logic r);
      sched_result_type res;
      logic [rrts_pkg::TASK_W-1:0] before_task;
      bit sw;
      bit idle;
      bit acc;
      before_task = cur_live ? cur_task : '0;
      sw = 1'b0;
      idle = 1'b0;
      acc = 1'b0;
      case (m)
         rrts_pkg::MODE_ADD: begin
            if (r) acc = enqueue_task(t);
         end
         rrts_pkg::MODE_REMOVE: begin
            acc = dequeue_task(t);
         end
         rrts_pkg::MODE_DISPATCH: begin
            acc = 1'b1;
            if (ready_line.size() == 0) begin
               cur_task = '0;
               idle = 1'b1;
            end else begin
               cur_task = ready_line[0];
               void'(dequeue_task(cur_task));
            end
            cur_live = 1'b1;
            slice_count = cfg_slice;
         end
         rrts_pkg::MODE_TICK: begin
            if (cfg_enable && cur_live) begin
               acc = 1'b1;
               run_tally[cur_task] = run_tally[cur_task] + 1'b1;
               if (slice_count != '0) slice_count = slice_count - 1'b1;
               if (slice_count == '0) begin
                  if (ready_line.size() > 0) begin
                     if (r) void'(enqueue_task(cur_task));
                     sw = promote_head();
                  end else begin
                     slice_count = cfg_slice;
                  end
               end
            end
         end
         rrts_pkg::MODE_YIELD: begin
            if (cfg_enable && cur_live) begin
               acc = 1'b1;
               if (ready_line.size() > 0) begin
                  if (r) begin
                     slice_count = cfg_slice;
                     void'(enqueue_task(cur_task));
                  end
                  sw = promote_head();
               end
            end
         end
         default: ;
      endcase
      res.next_task       = cur_live ? cur_task : '0;
      res.prev_task       = before_task;
      res.switched        = sw;
      res.idle_chosen     = idle;
      res.accepted        = acc;
      res.ready_count     = rrts_pkg::POS_W'(ready_line.size());
      res.slice_remaining = slice_count;
      res.run_ticks       = cur_live ? run_tally[cur_task] : '0;
      return res;
   endfunction

   function automatic sched_result_type mk_res(input logic [rrts_pkg::TASK_W-1:0] nt,
                                               input logic [rrts_pkg::TASK_W-1:0] pt,
                                               input logic sw, input logic idle,
                                               input logic acc,
                                               input logic [rrts_pkg::POS_W-1:0] rc,
                                               input logic [rrts_pkg::SLICE_W-1:0] sl,
                                               input logic [rrts_pkg::TICKS_W-1:0] tk);
      sched_result_type res;
      res = {nt, pt, sw, idle, acc, rc, sl, tk};
      return res;
   endfunction

   task automatic check_result(input sched_result_type got, input sched_result_type want);
      if (got.next_task !== want.next_task)
         flag_mismatch($sformatf("next_task %0d, want %0d", got.next_task, want.next_task));
      if (got.prev_task !== want.prev_task)
         flag_mismatch($sformatf("prev_task %0d, want %0d", got.prev_task, want.prev_task));
      if (got.switched !== want.switched)
         flag_mismatch($sformatf("switched %b, want %b", got.switched, want.switched));
      if (got.idle_chosen !== want.idle_chosen)
         flag_mismatch($sformatf("idle_chosen %b, want %b", got.idle_chosen,
                                 want.idle_chosen));
      if (got.accepted !== want.accepted)
         flag_mismatch($sformatf("accepted %b, want %b", got.accepted, want.accepted));
      if (got.ready_count !== want.ready_count)
         flag_mismatch($sformatf("ready_count %0d, want %0d", got.ready_count,
                                 want.ready_count));
      if (got.slice_remaining !== want.slice_remaining)
         flag_mismatch($sformatf("slice_remaining %0d, want %0d", got.slice_remaining,
                                 want.slice_remaining));
      if (got.run_ticks !== want.run_ticks)
         flag_mismatch($sformatf("current_run_ticks %0d, want %0d", got.run_ticks,
                                 want.run_ticks));
   endtask

   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_next_task, rsp_prev_task, rsp_switched, rsp_idle_chosen,
                   rsp_accepted, rsp_ready_count, rsp_slice_remaining,
                   rsp_current_run_ticks};
            if (pending_results.size() == 0) begin
               flag_mismatch("result beat with nothing expected");
            end else begin
               check_result(got, pending_results.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            want = schedule_event(req_mode, req_task_id, req_runnable);
            if (beat_typed) want = beat_res;
            pending_results.push_back(want);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      pressure_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!quiet && pressure_on && !pressure_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            pressure_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat (quiet ? 1 : $urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   task automatic send_beat(input logic [rrts_pkg::MODE_W-1:0] m,
                            input logic [rrts_pkg::TASK_W-1:0] t,
                            input logic r, input bit typed, input sched_result_type res);
      int gap;
      gap = 0;
      if (!quiet && !(pressure_on && !pressure_done) && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 18);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_task_id  <= t;
      req_runnable <= r;
      beat_typed   <= typed;
      beat_res     <= res;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rrts_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rrts_pkg::CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == rrts_pkg::REG_TIME_SLICE) cfg_slice = val;
      else cfg_enable = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(input logic [rrts_pkg::MODE_W-1:0] m,
                                   input logic [rrts_pkg::TASK_W-1:0] t,
                                   input logic r);
      step_row_type row;
      row = '{default: '0};
      row.mode = m;
      row.tid  = t;
      row.run  = r;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic [rrts_pkg::MODE_W-1:0] m,
                                     input logic [rrts_pkg::TASK_W-1:0] t,
                                     input logic r, input sched_result_type res);
      add_row(m, t, r);
      dir_rows[$].typed = 1'b1;
      dir_rows[$].res   = res;
   endfunction

   function automatic void add_csr(input logic [rrts_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [rrts_pkg::CSR_DAT_W-1:0] val);
      step_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.data   = val;
      dir_rows.push_back(row);
   endfunction

   initial begin
      sched_result_type               none_res;
      logic [rrts_pkg::MODE_W-1:0]    m;
      logic [rrts_pkg::TASK_W-1:0]    t;
      logic                           r;
      logic [rrts_pkg::CSR_DAT_W-1:0] slice_pick;
      int                             pick;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = rrts_pkg::MODE_ADD;
      req_task_id  = '0;
      req_runnable = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = rrts_pkg::REG_TIME_SLICE;
      csr_data     = '0;
      beat_typed   = 1'b0;
      beat_res     = '0;
      quiet        = 1'b0;
      pressure_on  = 1'b0;
      fail_count   = 0;
      cur_task     = '0;
      cur_live     = 1'b0;
      slice_count  = '0;
      cfg_slice    = rrts_pkg::SLICE_DEFAULT;
      cfg_enable   = 1'b0;
      foreach (run_tally[i]) begin
         run_tally[i] = '0;
         in_line[i]   = 1'b0;
      end
      none_res = '0;

      add_typed(rrts_pkg::MODE_TICK,     4'd0,  1'b1, none_res);
      add_typed(rrts_pkg::MODE_YIELD,    4'd0,  1'b1, none_res);
      add_typed(MODE_BAD_LO,             4'd5,  1'b1, none_res);
      add_typed(MODE_BAD_HI,             4'd15, 1'b0, none_res);
      add_typed(rrts_pkg::MODE_REMOVE,   4'd3,  1'b1, none_res);
      add_typed(rrts_pkg::MODE_ADD,      4'd15, 1'b0, none_res);
      add_typed(rrts_pkg::MODE_DISPATCH, 4'd0,  1'b0,
                mk_res(4'd0, 4'd0, 1'b0, 1'b1, 1'b1, 5'd0, rrts_pkg::SLICE_DEFAULT, 32'd0));
      add_typed(rrts_pkg::MODE_ADD,      4'd15, 1'b1,
                mk_res(4'd0, 4'd0, 1'b0, 1'b0, 1'b1, 5'd1, rrts_pkg::SLICE_DEFAULT, 32'd0));
      add_typed(rrts_pkg::MODE_ADD,      4'd15, 1'b1,
                mk_res(4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd1, rrts_pkg::SLICE_DEFAULT, 32'd0));
      add_row(rrts_pkg::MODE_ADD,        4'd0,  1'b1);
      add_row(rrts_pkg::MODE_ADD,        4'd7,  1'b1);
      add_typed(rrts_pkg::MODE_TICK,     4'd0,  1'b1,
                mk_res(4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd3, rrts_pkg::SLICE_DEFAULT, 32'd0));
      add_csr(rrts_pkg::REG_TIME_SLICE, 8'd1);
      add_csr(rrts_pkg::REG_SCHED_ENABLE, 8'd1);
      add_row(rrts_pkg::MODE_DISPATCH,   4'd0,  1'b1);
      add_row(rrts_pkg::MODE_TICK,       4'd0,  1'b1);
      add_row(rrts_pkg::MODE_TICK,       4'd0,  1'b0);
      add_row(rrts_pkg::MODE_YIELD,      4'd0,  1'b1);
      add_row(rrts_pkg::MODE_YIELD,      4'd0,  1'b0);
      add_row(rrts_pkg::MODE_YIELD,      4'd0,  1'b1);
      add_row(rrts_pkg::MODE_TICK,       4'd0,  1'b1);
      add_row(rrts_pkg::MODE_ADD,        4'd7,  1'b1);
      add_row(rrts_pkg::MODE_TICK,       4'd0,  1'b1);
      add_row(rrts_pkg::MODE_ADD,        4'd3,  1'b1);
      add_row(rrts_pkg::MODE_REMOVE,     4'd3,  1'b0);
      add_csr(rrts_pkg::REG_TIME_SLICE, 8'd0);
      add_row(rrts_pkg::MODE_TICK,       4'd0,  1'b1);
      add_row(rrts_pkg::MODE_ADD,        4'd9,  1'b1);
      add_row(rrts_pkg::MODE_TICK,       4'd0,  1'b1);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            settle();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_beat(dir_rows[i].mode, dir_rows[i].tid, dir_rows[i].run,
                      dir_rows[i].typed, dir_rows[i].res);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         quiet = (ph == PHASES - 1);
         case (ph)
            0: slice_pick = 8'd1;
            1: slice_pick = 8'd3;
            2: slice_pick = 8'd2;
            3: slice_pick = 8'd0;
            4: slice_pick = 8'd255;
            6: slice_pick = 8'd1;
            default: slice_pick = rrts_pkg::CSR_DAT_W'($urandom_range(2, 6));
         endcase
         write_reg(rrts_pkg::REG_TIME_SLICE, slice_pick);
         write_reg(rrts_pkg::REG_SCHED_ENABLE, (ph == 2) ? 8'd0 : 8'd1);
         if (ph == 1) pressure_on = 1'b1;
         repeat (PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) m = rrts_pkg::MODE_ADD;
            else if (pick < 42) m = rrts_pkg::MODE_REMOVE;
            else if (pick < 50) m = rrts_pkg::MODE_DISPATCH;
            else if (pick < 80) m = rrts_pkg::MODE_TICK;
            else if (pick < 94) m = rrts_pkg::MODE_YIELD;
            else m = rrts_pkg::MODE_YIELD + rrts_pkg::MODE_W'($urandom_range(1, 3));
            t = ($urandom_range(0, 1) == 0)
                   ? rrts_pkg::TASK_W'($urandom_range(0, 5))
                   : rrts_pkg::TASK_W'($urandom_range(0, rrts_pkg::NUM_TASKS - 1));
            r = ($urandom_range(0, 4) != 0);
            send_beat(m, t, r, 1'b0, none_res);
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
